// File: rtl/prqd_pkg.sv
// ----------------------------------------------------------------------------
// prqd_pkg
// Types, codes and default sizes shared by the priority ready queue dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package prqd_pkg;

    localparam int DEF_NUM_LEVELS  = 4;
    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int DEF_NUM_PROCS   = 16;
    localparam int MAX_RESULTS     = 64;

    localparam int OP_W   = 2;
    localparam int PID_W  = 4;
    localparam int PRIO_W = 8;
    localparam int KIND_W = 3;

    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
    localparam logic [OP_W-1:0] OP_KILL     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DISPATCHED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ZOMBIFIED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PID_W-1:0]  proc_id;
        logic [PRIO_W-1:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PID_W-1:0]  proc_id_res;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic pop;
    } lvl_cmd_t;

endpackage

`default_nettype wire

// File: rtl/prqd_ram.sv
// ----------------------------------------------------------------------------
// prqd_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prqd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/prqd_levels.sv
// ----------------------------------------------------------------------------
// prqd_levels
// Head and count registers of each priority level, with the lowest-numbered
// non-empty level search.
// ----------------------------------------------------------------------------
`default_nettype none

module prqd_levels
    import prqd_pkg::*;
#(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    localparam int LVW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
    localparam int IW  = $clog2(LEVEL_DEPTH),
    localparam int CW  = $clog2(LEVEL_DEPTH + 1)
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lvl_cmd_t       cmd,
    input  wire logic [LVW-1:0] sel_lv,
    output      logic [IW-1:0]  head_sel,
    output      logic [CW-1:0]  count_sel,
    output      logic [LVW-1:0] first_lv,
    output      logic           any_queued
);

    logic [IW-1:0] heads_reg  [NUM_LEVELS];
    logic [IW-1:0] heads_next [NUM_LEVELS];
    logic [CW-1:0] counts_reg  [NUM_LEVELS];
    logic [CW-1:0] counts_next [NUM_LEVELS];

    assign head_sel  = heads_reg[sel_lv];
    assign count_sel = counts_reg[sel_lv];

    always_comb
    begin
        first_lv   = '0;
        any_queued = 1'b0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (counts_reg[i] != '0)
            begin
                first_lv   = LVW'(i);
                any_queued = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            heads_next[i]  = heads_reg[i];
            counts_next[i] = counts_reg[i];
        end
        if (cmd.push)
        begin
            counts_next[sel_lv] = counts_reg[sel_lv] + CW'(1);
        end
        else if (cmd.pop)
        begin
            counts_next[sel_lv] = counts_reg[sel_lv] - CW'(1);
            if (heads_reg[sel_lv] == IW'(LEVEL_DEPTH - 1))
            begin
                heads_next[sel_lv] = '0;
            end
            else
            begin
                heads_next[sel_lv] = heads_reg[sel_lv] + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                heads_reg[i]  <= heads_next[i];
                counts_reg[i] <= counts_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/priority_ready_queue_dispatcher.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_dispatcher
// Strict-priority ready queue: one ring FIFO per level in a shared slot RAM.
// ----------------------------------------------------------------------------
// Works on one input beat at a time. Schedule, kill and unused ops are
// accepted, then executed. A dispatch is accepted, then for every entry it
// pops issues a slot RAM read and checks the registered read data against
// the killed marks; when every level is empty it returns an empty result.
// Result beats sit in an output register, so a result is not loaded until
// the previous one has been taken. A dispatch stops after MAX_RESULTS
// zombified results, leaving the rest queued. There is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_dispatcher
    import prqd_pkg::*;
#(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int NUM_PROCS   = DEF_NUM_PROCS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output      logic      in_ready,
    input  wire in_item_t  in_data,
    output      logic      out_valid,
    input  wire logic      out_ready,
    output      out_item_t out_data
);

    localparam int LVW   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int IW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int SLOTS = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int MARKS = (NUM_PROCS < (1 << PID_W)) ? NUM_PROCS : (1 << PID_W);
    localparam int MKW   = $clog2(MARKS);
    localparam int ZW    = $clog2(MAX_RESULTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [PID_W-1:0] id_reg, id_next;
    logic [LVW-1:0]   lv_reg, lv_next;
    logic [ZW-1:0]    zcnt_reg, zcnt_next;
    logic [MARKS-1:0] marks_reg, marks_next;
    logic [PID_W-1:0] cur_reg, cur_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    lvl_cmd_t         lvl_cmd;
    logic [LVW-1:0]   sel_lv;
    logic [IW-1:0]    head_sel;
    logic [CW-1:0]    count_sel;
    logic [LVW-1:0]   first_lv;
    logic             any_queued;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [PID_W-1:0] ram_rdata;

    logic [IW:0]      tail_sum;
    logic [IW-1:0]    tail_idx;
    logic             out_free;
    logic             load;
    logic             rd_killed;
    logic             id_has_mark;

    prqd_levels #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_levels (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (lvl_cmd),
        .sel_lv     (sel_lv),
        .head_sel   (head_sel),
        .count_sel  (count_sel),
        .first_lv   (first_lv),
        .any_queued (any_queued)
    );

    prqd_ram #(
        .WIDTH (PID_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (id_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign sel_lv = (op_reg == OP_DISPATCH) ? first_lv : lv_reg;

    assign tail_sum  = {1'b0, head_sel} + (IW + 1)'(count_sel);
    assign tail_idx  = (32'(tail_sum) >= LEVEL_DEPTH) ?
                       IW'(tail_sum - (IW + 1)'(LEVEL_DEPTH)) : tail_sum[IW-1:0];
    assign ram_waddr = AW'(AW'(sel_lv) * AW'(LEVEL_DEPTH)) + AW'(tail_idx);
    assign ram_raddr = AW'(AW'(sel_lv) * AW'(LEVEL_DEPTH)) + AW'(head_sel);

    assign id_has_mark = (32'(id_reg) < MARKS);
    assign rd_killed   = (32'(ram_rdata) < MARKS) && marks_reg[ram_rdata[MKW-1:0]];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        lv_next        = lv_reg;
        zcnt_next      = zcnt_reg;
        marks_next     = marks_reg;
        cur_next       = cur_reg;
        lvl_cmd        = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        load           = 1'b0;
        out_next       = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_data.op;
                    id_next   = in_data.proc_id;
                    zcnt_next = '0;
                    if (32'(in_data.priority_req) >= NUM_LEVELS)
                    begin
                        lv_next = LVW'(NUM_LEVELS - 1);
                    end
                    else
                    begin
                        lv_next = LVW'(in_data.priority_req);
                    end
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_SCHEDULE:
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = S_IDLE;
                            if (count_sel == CW'(LEVEL_DEPTH))
                            begin
                                out_next = '{kind: KIND_FULL, proc_id_res: id_reg, last: 1'b1};
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                lvl_cmd.push = 1'b1;
                                if (id_has_mark)
                                begin
                                    marks_next[id_reg[MKW-1:0]] = 1'b0;
                                end
                                out_next = '{kind: KIND_ACCEPTED, proc_id_res: id_reg,
                                             last: 1'b1};
                            end
                        end
                    end
                    OP_KILL:
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = S_IDLE;
                            if (id_has_mark)
                            begin
                                marks_next[id_reg[MKW-1:0]] = 1'b1;
                            end
                            out_next = '{kind: KIND_ACCEPTED, proc_id_res: id_reg, last: 1'b1};
                        end
                    end
                    OP_DISPATCH:
                    begin
                        if (!any_queued)
                        begin
                            if (out_free)
                            begin
                                load       = 1'b1;
                                state_next = S_IDLE;
                                out_next   = '{kind: KIND_EMPTY, proc_id_res: '0, last: 1'b1};
                            end
                        end
                        else
                        begin
                            ram_re      = 1'b1;
                            lvl_cmd.pop = 1'b1;
                            state_next  = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (!rd_killed)
                    begin
                        cur_next   = ram_rdata;
                        state_next = S_IDLE;
                        out_next   = '{kind: KIND_DISPATCHED, proc_id_res: ram_rdata,
                                       last: 1'b1};
                    end
                    else
                    begin
                        zcnt_next = zcnt_reg + ZW'(1);
                        if (zcnt_reg == ZW'(MAX_RESULTS - 1))
                        begin
                            state_next = S_IDLE;
                            out_next   = '{kind: KIND_ZOMBIFIED, proc_id_res: ram_rdata,
                                           last: 1'b1};
                        end
                        else
                        begin
                            state_next = S_EXEC;
                            out_next   = '{kind: KIND_ZOMBIFIED, proc_id_res: ram_rdata,
                                           last: 1'b0};
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SCHEDULE;
            zcnt_reg      <= '0;
            marks_reg     <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            zcnt_reg      <= zcnt_next;
            marks_reg     <= marks_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        lv_reg  <= lv_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_cur_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_DISPATCHED) |-> cur_reg == out_reg.proc_id_res)
        else $error("current process differs from dispatched result");

    a_not_last_zombie: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> out_reg.kind == KIND_ZOMBIFIED)
        else $error("non-final result that is not a zombie");

    a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ($past(state_reg) == S_READ || $past(ram_re)))
        else $error("slot check without a preceding slot read");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && (ram_re || lvl_cmd.pop)))
        else $error("slot write overlaps a pop");
`endif

endmodule

`default_nettype wire
